// File: hw/rtl/cursor_line_editor_defines.svh
// assertion macros for the cursor line editor checker
// no dependencies; taken in by the checker file only
`ifndef CURSOR_LINE_EDITOR_DEFINES_SVH
`define CURSOR_LINE_EDITOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CLE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cle_pkg.sv
// shared types, key codes and command/status bundles for the cursor line editor
// no dependencies
`timescale 1ns / 1ps

package cle_pkg;

    // key codes with special meaning
    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    // input beat
    typedef struct packed {
        logic       cmd;
        logic [7:0] key_byte;
    } cle_in_t;

    // result beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       empty_line;
        logic       overflow;
    } cle_out_t;

    typedef enum logic [1:0] {
        KIND_INSERT,
        KIND_LEFT,
        KIND_RIGHT,
        KIND_BACK
    } cle_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE_L,
        ST_MOVE_R,
        ST_DRAIN_RD,
        ST_DRAIN_LD,
        ST_DRAIN_OUT,
        ST_EMPTY_OUT
    } cle_state_t;

    // controller to datapath
    typedef struct packed {
        logic ins_we;
        logic set_ovf;
        logic back;
        logic left_rd;
        logic left_wr;
        logic right_rd;
        logic right_wr;
        logic drain_start;
        logic drain_rd;
        logic drain_next;
        logic out_load;
        logic out_load_empty;
        logic clear;
    } cle_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic      is_eol;
        cle_kind_t kind;
        logic      bc_zero;
        logic      ac_zero;
        logic      full;
        logic      total_zero;
        logic      drain_last;
    } cle_sts_t;

    function automatic cle_kind_t key_decode(input logic [7:0] key);
        cle_kind_t k;
        unique case (key)
            KEY_LEFT:  k = KIND_LEFT;
            KEY_RIGHT: k = KIND_RIGHT;
            KEY_BACK:  k = KIND_BACK;
            default:   k = KIND_INSERT;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/cle_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: hw/rtl/cle_datapath.sv
// datapath: the two stack rams, stack counts, drain index, overflow flag, result register
// depends on cle_pkg and cle_ram
`timescale 1ns / 1ps

module cle_datapath #(
    parameter int LINE_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cle_pkg::cle_in_t  s_payload,
    input  cle_pkg::cle_cmd_t cmd,
    output cle_pkg::cle_sts_t sts,
    output cle_pkg::cle_out_t m_payload
);
    import cle_pkg::*;

    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);

    logic [CW-1:0] bc_reg, bc_next;
    logic [CW-1:0] ac_reg, ac_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          ovf_reg, ovf_next;
    logic          sel_reg;
    cle_out_t      out_reg;

    logic [CW-1:0] total;
    logic [CW-1:0] bc_m1;
    logic [CW-1:0] ac_m1;
    logic [CW-1:0] drain_after_pos;
    logic          drain_in_after;

    logic          b_we, b_re, a_we, a_re;
    logic [AW-1:0] b_wr_addr, b_rd_addr, a_wr_addr, a_rd_addr;
    logic [7:0]    b_wr_data, b_rd_data, a_wr_data, a_rd_data;

    assign total           = bc_reg + ac_reg;
    assign bc_m1           = bc_reg - 1'b1;
    assign ac_m1           = ac_reg - 1'b1;
    assign drain_after_pos = total - 1'b1 - idx_reg;
    assign drain_in_after  = (idx_reg >= bc_reg);

    // text before the cursor, entry 0 is the first character of the line
    assign b_we      = cmd.ins_we | cmd.right_wr;
    assign b_wr_addr = bc_reg[AW-1:0];
    assign b_wr_data = cmd.right_wr ? a_rd_data : s_payload.key_byte;
    assign b_re      = cmd.left_rd | (cmd.drain_rd & ~drain_in_after);
    assign b_rd_addr = cmd.left_rd ? bc_m1[AW-1:0] : idx_reg[AW-1:0];

    cle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_before (
        .aclk    (aclk),
        .we      (b_we),
        .wr_addr (b_wr_addr),
        .wr_data (b_wr_data),
        .re      (b_re),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // text after the cursor, entry 0 is the last character of the line
    assign a_we      = cmd.left_wr;
    assign a_wr_addr = ac_reg[AW-1:0];
    assign a_wr_data = b_rd_data;
    assign a_re      = cmd.right_rd | (cmd.drain_rd & drain_in_after);
    assign a_rd_addr = cmd.right_rd ? ac_m1[AW-1:0] : drain_after_pos[AW-1:0];

    cle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_after (
        .aclk    (aclk),
        .we      (a_we),
        .wr_addr (a_wr_addr),
        .wr_data (a_wr_data),
        .re      (a_re),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    // counts, drain index and sticky overflow
    always_comb begin
        bc_next  = bc_reg;
        ac_next  = ac_reg;
        idx_next = idx_reg;
        ovf_next = ovf_reg | cmd.set_ovf;
        if (cmd.clear) begin
            bc_next = '0;
            ac_next = '0;
        end else begin
            if (cmd.ins_we | cmd.right_wr) begin
                bc_next = bc_reg + 1'b1;
            end
            if (cmd.back | cmd.left_wr) begin
                bc_next = bc_m1;
            end
            if (cmd.left_wr) begin
                ac_next = ac_reg + 1'b1;
            end
            if (cmd.right_wr) begin
                ac_next = ac_m1;
            end
        end
        if (cmd.drain_start) begin
            idx_next = '0;
        end else if (cmd.drain_next) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg  <= '0;
            ac_reg  <= '0;
            idx_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            bc_reg  <= bc_next;
            ac_reg  <= ac_next;
            idx_reg <= idx_next;
            ovf_reg <= ovf_next;
        end
    end

    // result register and read-side select
    always_ff @(posedge aclk) begin
        if (cmd.drain_rd) begin
            sel_reg <= drain_in_after;
        end
        if (cmd.out_load_empty) begin
            out_reg.out_char   <= '0;
            out_reg.last       <= 1'b1;
            out_reg.empty_line <= 1'b1;
            out_reg.overflow   <= ovf_reg;
        end else if (cmd.out_load) begin
            out_reg.out_char   <= sel_reg ? a_rd_data : b_rd_data;
            out_reg.last       <= sts.drain_last;
            out_reg.empty_line <= 1'b0;
            out_reg.overflow   <= ovf_reg;
        end
    end

    assign m_payload = out_reg;

    // status toward the controller
    always_comb begin
        sts.is_eol     = s_payload.cmd;
        sts.kind       = key_decode(s_payload.key_byte);
        sts.bc_zero    = (bc_reg == '0);
        sts.ac_zero    = (ac_reg == '0);
        sts.full       = (total == CW'(LINE_DEPTH));
        sts.total_zero = (total == '0);
        sts.drain_last = (idx_reg == total - 1'b1);
    end
endmodule

// File: hw/rtl/cle_ctrl.sv
// controller state machine: input and result handshakes, datapath commands
// depends on cle_pkg
`timescale 1ns / 1ps

module cle_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  cle_pkg::cle_sts_t sts,
    output cle_pkg::cle_cmd_t cmd
);
    import cle_pkg::*;

    cle_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // no beat is taken while reset is held
                s_ready = aresetn;
                if (s_valid && s_ready) begin
                    if (sts.is_eol) begin
                        if (sts.total_zero) begin
                            cmd.out_load_empty = 1'b1;
                            state_next         = ST_EMPTY_OUT;
                        end else begin
                            cmd.drain_start = 1'b1;
                            state_next      = ST_DRAIN_RD;
                        end
                    end else begin
                        unique case (sts.kind)
                            KIND_LEFT: begin
                                if (!sts.bc_zero) begin
                                    cmd.left_rd = 1'b1;
                                    state_next  = ST_MOVE_L;
                                end
                            end
                            KIND_RIGHT: begin
                                if (!sts.ac_zero) begin
                                    cmd.right_rd = 1'b1;
                                    state_next   = ST_MOVE_R;
                                end
                            end
                            KIND_BACK: begin
                                cmd.back = ~sts.bc_zero;
                            end
                            KIND_INSERT: begin
                                cmd.set_ovf = sts.full;
                                cmd.ins_we  = ~sts.full;
                            end
                            default: begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_MOVE_L: begin
                cmd.left_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_MOVE_R: begin
                cmd.right_wr = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_DRAIN_RD: begin
                cmd.drain_rd = 1'b1;
                state_next   = ST_DRAIN_LD;
            end
            ST_DRAIN_LD: begin
                cmd.out_load = 1'b1;
                state_next   = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (sts.drain_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.drain_next = 1'b1;
                        state_next     = ST_DRAIN_RD;
                    end
                end
            end
            ST_EMPTY_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// File: hw/rtl/cursor_line_editor.sv
// top level of the cursor line editor: controller plus datapath
// depends on cle_pkg, cle_ctrl, cle_datapath (and cle_ram below it)
`timescale 1ns / 1ps

// Keystroke line editor holding up to LINE_DEPTH characters as two stacks
// (text before and after the cursor), each in its own ram. It takes one beat
// at a time; s_ready stays low while aresetn is low. An insert, a backspace,
// or a key with no effect is applied in the idle state. A cursor move is a
// registered read of one stack ram followed by the write into the other.
// End of line starts a drain that emits the line one character per result
// beat, each through a ram read, a result load and the handshake, plus any
// stall on m_ready; an empty line gives a single result beat and its handshake.
// Inserts into a full buffer are dropped and set a sticky overflow bit
// carried on every result; only reset clears it. No clearing pass is needed
// after reset.
module cursor_line_editor #(
    parameter int LINE_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cle_pkg::cle_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output cle_pkg::cle_out_t m_payload
);
    import cle_pkg::*;

    cle_cmd_t cmd;
    cle_sts_t sts;

    cle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cle_datapath #(.LINE_DEPTH(LINE_DEPTH)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_payload (m_payload)
    );
endmodule

// File: hw/rtl/cle_checker.sv
// port-level checks for the cursor line editor, bound to the top level
// depends on cle_pkg and cursor_line_editor_defines.svh
`timescale 1ns / 1ps
`include "cursor_line_editor_defines.svh"

module cle_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input cle_pkg::cle_in_t  s_payload,
    input logic              m_valid,
    input logic              m_ready,
    input cle_pkg::cle_out_t m_payload
);
    import cle_pkg::*;

    logic in_beat;
    assign in_beat = s_valid & s_ready & s_payload.cmd;

    // a stalled result beat holds its payload
    `CLE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_payload), "result payload changed while stalled")
    // an empty line is a single beat with a zero character
    `CLE_ASSERT_NOW(a_empty_last, aclk, aresetn, m_valid && m_payload.empty_line, m_payload.last && (m_payload.out_char == 8'h00), "empty line result malformed")
    // no new beat is taken while a result is on offer
    `CLE_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "input taken while result pending")
    // s_ready drops once an end of line beat is taken
    `CLE_ASSERT_NEXT(a_eol_busy, aclk, aresetn, in_beat, !s_ready, "end of line did not start a drain")
endmodule

bind cursor_line_editor cle_checker u_cle_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

// File: dv/testbench.sv
// self-checking testbench for the cursor line editor: random keystroke lines, line checker
// depends on cle_pkg and cursor_line_editor
`timescale 1ns / 1ps

module testbench;
    import cle_pkg::*;

    localparam int LINE_DEPTH    = 64;
    localparam int DIRECTED_KEYS = 19;
    localparam int RANDOM_KEYS   = 350;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 250;
    localparam int REPORT_LIMIT  = 10;

    // two-stack mirror of the editor plus the queue of characters it still owes
    class line_mirror;
        logic [7:0] head_text [LINE_DEPTH];
        logic [7:0] tail_text [LINE_DEPTH];
        int         head_len = 0;
        int         tail_len = 0;
        bit         overflow_seen = 1'b0;
        cle_out_t   pending_chars [$];
        int         failures = 0;

        // apply one accepted input beat and queue the characters it emits
        function void note_beat(cle_in_t beat);
            cle_out_t ch;
            int       total;
            int       n;
            if (!beat.cmd) begin
                case (beat.key_byte)
                    KEY_LEFT: begin
                        if (head_len > 0 && tail_len < LINE_DEPTH) begin
                            head_len--;
                            tail_text[tail_len] = head_text[head_len];
                            tail_len++;
                        end
                    end
                    KEY_RIGHT: begin
                        if (tail_len > 0 && head_len < LINE_DEPTH) begin
                            tail_len--;
                            head_text[head_len] = tail_text[tail_len];
                            head_len++;
                        end
                    end
                    KEY_BACK: begin
                        if (head_len > 0) head_len--;
                    end
                    default: begin
                        if (head_len + tail_len >= LINE_DEPTH) begin
                            overflow_seen = 1'b1;
                        end else begin
                            head_text[head_len] = beat.key_byte;
                            head_len++;
                        end
                    end
                endcase
                return;
            end
            // end of line: walk the line in order, then clear it
            total = head_len + tail_len;
            ch.overflow = overflow_seen;
            if (total == 0) begin
                ch.out_char   = 8'h00;
                ch.last       = 1'b1;
                ch.empty_line = 1'b1;
                pending_chars.push_back(ch);
                return;
            end
            n = 0;
            ch.empty_line = 1'b0;
            for (int i = 0; i < head_len; i++) begin
                ch.out_char = head_text[i];
                ch.last     = (n + 1 == total);
                pending_chars.push_back(ch);
                n++;
            end
            for (int i = tail_len; i > 0; i--) begin
                ch.out_char = tail_text[i - 1];
                ch.last     = (n + 1 == total);
                pending_chars.push_back(ch);
                n++;
            end
            head_len = 0;
            tail_len = 0;
        endfunction

        // compare one accepted result beat with the oldest owed character
        function void check_char(cle_out_t got);
            cle_out_t want;
            if (pending_chars.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result beat: char %02h last %0b empty %0b ovf %0b",
                             got.out_char, got.last, got.empty_line, got.overflow);
                return;
            end
            want = pending_chars.pop_front();
            if (got.out_char !== want.out_char || got.last !== want.last ||
                got.empty_line !== want.empty_line || got.overflow !== want.overflow) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: expected char %02h last %0b empty %0b ovf %0b,",
                             want.out_char, want.last, want.empty_line, want.overflow,
                             " got char %02h last %0b empty %0b ovf %0b",
                             got.out_char, got.last, got.empty_line, got.overflow);
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    cle_in_t   s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    cle_out_t  m_payload;

    line_mirror mirror = new();
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_request = 1'b0;
    int         keys_sent = 0;

    cursor_line_editor #(
        .LINE_DEPTH(LINE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always #5 aclk = ~aclk;

    // offer one beat, with random idle cycles ahead of it, and note it once taken
    task automatic send_beat(input logic is_eol, input logic [7:0] key);
        cle_in_t beat;
        beat.cmd      = is_eol;
        beat.key_byte = key;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
        mirror.note_beat(beat);
        keys_sent++;
    endtask

    // insertable byte: anything but the three edit keys
    function automatic logic [7:0] pick_char();
        logic [7:0] k;
        do k = 8'($urandom_range(0, 255));
        while (k == KEY_LEFT || k == KEY_RIGHT || k == KEY_BACK);
        return k;
    endfunction

    function automatic logic [7:0] pick_edit_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 52) return 8'($urandom_range(0, 255));
        if (roll < 68) return KEY_LEFT;
        if (roll < 84) return KEY_RIGHT;
        return KEY_BACK;
    endfunction

    // ordinary line: a few random edits then end of line
    task automatic send_edit_line(input int n_keys);
        repeat (n_keys) send_beat(1'b0, pick_edit_key());
        send_beat(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // line that runs past capacity, cursor moves mixed in
    task automatic send_full_line();
        int n_ins;
        n_ins = $urandom_range(LINE_DEPTH + 1, LINE_DEPTH + 6);
        while (n_ins > 0) begin
            case ($urandom_range(0, 9))
                0: send_beat(1'b0, KEY_LEFT);
                1: send_beat(1'b0, KEY_RIGHT);
                default: begin
                    send_beat(1'b0, pick_char());
                    n_ins--;
                end
            endcase
        end
        send_beat(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // result side: check accepted beats, stall at random or hold off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) mirror.check_char(m_payload);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int roll;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty lines, edits at both edges, byte extremes
        send_beat(1'b1, 8'hFF);
        send_beat(1'b0, KEY_LEFT);
        send_beat(1'b0, KEY_RIGHT);
        send_beat(1'b0, KEY_BACK);
        send_beat(1'b1, 8'h00);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'h61);
        repeat (4) send_beat(1'b0, KEY_LEFT);
        send_beat(1'b0, 8'h62);
        repeat (4) send_beat(1'b0, KEY_RIGHT);
        send_beat(1'b0, KEY_BACK);
        send_beat(1'b1, KEY_LEFT);

        // random lines over four idle/stall phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            // long receiver hold-off while lines keep coming
            if (phase == 0) hold_request = 1'b1;
            if (phase == 1) send_full_line();
            while (keys_sent < DIRECTED_KEYS + (phase + 1) * RANDOM_KEYS / 4) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    send_full_line();
                end else if (roll < 90) begin
                    send_edit_line($urandom_range(0, 12));
                end else begin
                    repeat ($urandom_range(1, 4))
                        send_beat(1'($urandom_range(0, 4) == 0), 8'($urandom_range(0, 255)));
                end
            end
        end
        s_valid <= 1'b0;

        // drain what is still owed, then watch for strays
        while (mirror.pending_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        mirror.failures += mirror.pending_chars.size();
        if (mirror.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
